>>> design/tdt_pkg.sv
// shared types and codes for the tile lookup-or-insert table
package tdt_pkg;

  // result field widths
  localparam int INDEX_W  = 8;
  localparam int STATUS_W = 2;
  localparam int COORD_W  = 8;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_MATCHED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ADDED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  // request side information carried along the chain
  typedef struct packed {
    logic [INDEX_W-1:0]  tile_index;
    logic [STATUS_W-1:0] status;
    logic [COORD_W-1:0]  map_space;
    logic [COORD_W-1:0]  pos_x;
    logic [COORD_W-1:0]  pos_y;
  } meta_t;

endpackage

>>> design/tdt_cell.sv
// one table entry with its compare logic and the chain stage behind it
module tdt_cell #(
  parameter int TILE_BITS  = 64,
  parameter int CELL_INDEX = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic                 in_valid,
  input  logic [TILE_BITS-1:0] in_key,
  input  tdt_pkg::meta_t       in_meta,
  output logic                 out_valid,
  output logic [TILE_BITS-1:0] out_key,
  output tdt_pkg::meta_t       out_meta,
  output logic                 entry_valid
);
  import tdt_pkg::*;

  localparam logic [INDEX_W-1:0] MY_IDX = INDEX_W'(CELL_INDEX);

  logic [TILE_BITS-1:0] entry;
  meta_t                meta_next;
  logic                 store;

  // compare against the held entry, or claim this entry when it is free
  always_comb begin
    meta_next = in_meta;
    store     = 1'b0;
    if (in_valid && (in_meta.status == ST_FULL)) begin
      if (entry_valid) begin
        if (entry == in_key) begin
          meta_next.status     = ST_MATCHED;
          meta_next.tile_index = MY_IDX;
        end
      end else begin
        store                = advance;
        meta_next.status     = ST_ADDED;
        meta_next.tile_index = MY_IDX;
      end
    end
  end

  // control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      entry_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= in_valid;
      end
      if (store) begin
        entry_valid <= 1'b1;
      end
    end
  end

  // payload and stored pattern
  always_ff @(posedge clk) begin
    if (advance) begin
      out_key  <= in_key;
      out_meta <= meta_next;
    end
    if (store) begin
      entry <= in_key;
    end
  end

endmodule

>>> design/tile_dedup_table.sv
// Tile pattern lookup-or-insert table built as a chain of entry cells.
// Input stream s_axis carries one request per tile: the pattern with its map
// space and position. Output stream m_axis returns one result per request,
// in request order: the entry index, a status (matched, added or full) and
// the echoed coordinates.
// Each request walks one cell per cycle while the chain advances. A cell whose
// entry equals the pattern marks it matched; the first free cell it meets
// stores the pattern and marks it added. A request that passes every cell
// unresolved leaves with status full and index zero, and nothing is stored.
// A result is driven onto m_axis from the last cell's stage, which is the
// output register. The chain moves one cell per cycle, so one request is
// accepted every cycle while it advances.
// When the receiver stalls a waiting result, the whole chain holds and
// s_axis_tready drops; nothing is lost or reordered.
// Reset clears the stage valid flags and the entry-in-use flags, leaving an
// empty table at once; no clearing pass is needed.
module tile_dedup_table #(
  parameter int TABLE_DEPTH = 256,
  parameter int TILE_BITS   = 64
) (
  input  logic        clk,
  input  logic        rst,
  // request: tile_pattern[63:0], map_space[71:64], pos_x[79:72], pos_y[87:80]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,
  // result: tile_index[7:0], out_space[15:8], out_x[23:16], out_y[31:24]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,
  // result: status[1:0]
  output logic [1:0]  m_axis_tuser
);
  import tdt_pkg::*;

  logic                 advance;
  logic                 link_valid [TABLE_DEPTH+1];
  logic [TILE_BITS-1:0] link_key   [TABLE_DEPTH+1];
  meta_t                link_meta  [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0] entry_valid;
  meta_t                in_meta;
  meta_t                res_meta;

  // the chain moves when the output slot is empty or being taken
  assign advance       = !link_valid[TABLE_DEPTH] || m_axis_tready;
  assign s_axis_tready = advance;

  // unpack the request; status full stands for not yet resolved
  always_comb begin
    in_meta.tile_index = '0;
    in_meta.status     = ST_FULL;
    in_meta.map_space  = s_axis_tdata[71:64];
    in_meta.pos_x      = s_axis_tdata[79:72];
    in_meta.pos_y      = s_axis_tdata[87:80];
  end

  assign link_valid[0] = s_axis_tvalid;
  assign link_key[0]   = s_axis_tdata[TILE_BITS-1:0];
  assign link_meta[0]  = in_meta;

  // row of entry cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    tdt_cell #(
      .TILE_BITS  (TILE_BITS),
      .CELL_INDEX (i)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .advance     (advance),
      .in_valid    (link_valid[i]),
      .in_key      (link_key[i]),
      .in_meta     (link_meta[i]),
      .out_valid   (link_valid[i+1]),
      .out_key     (link_key[i+1]),
      .out_meta    (link_meta[i+1]),
      .entry_valid (entry_valid[i])
    );
  end

  // result from the last stage
  assign res_meta      = link_meta[TABLE_DEPTH];
  assign m_axis_tvalid = link_valid[TABLE_DEPTH];
  assign m_axis_tdata  = {res_meta.pos_y, res_meta.pos_x, res_meta.map_space,
                          res_meta.tile_index};
  assign m_axis_tuser  = res_meta.status;

  // entries fill from the bottom up with no gaps
  a_fill_order : assert property (@(posedge clk) disable iff (rst)
    ((entry_valid + 1'b1) & entry_valid) == '0)
    else $error("entry flags are not contiguous from entry zero");

  // a full result only when every entry is in use
  a_full_only_when_full : assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == ST_FULL)) |-> (&entry_valid))
    else $error("full status while a free entry remains");

  // a full result carries index zero
  a_full_index_zero : assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == ST_FULL)) |-> (m_axis_tdata[7:0] == '0))
    else $error("full status with a nonzero index");

endmodule
